/* sv/psf_pkg.sv */
// Shared constants and codes for the prime sieve filter.
// No dependencies; compile this file first.
package psf_pkg;

    // Width of candidate, limit and stored primes.
    localparam int VALUE_W = 16;

    // Default depth of the prime table.
    localparam int MAX_PRIMES_DEF = 64;

    // Limit value after reset and the smallest prime.
    localparam logic [VALUE_W-1:0] LIMIT_RESET    = VALUE_W'(280);
    localparam logic [VALUE_W-1:0] SMALLEST_PRIME = VALUE_W'(2);

    // Result status codes.
    localparam logic ST_STORED = 1'b0;
    localparam logic ST_FULL   = 1'b1;

endpackage

/* sv/psf_if.sv */
// Valid/ready channel interfaces of the prime sieve filter.
// Depends on psf_pkg for the value width.

// Candidate request channel.
interface psf_cand_if import psf_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

// Result request channel.
interface psf_prime_if import psf_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] prime_value;
    logic               status;

    modport source (output valid, output prime_value, output status, input ready);
    modport sink   (input valid, input prime_value, input status, output ready);
endinterface

// Limit register write channel.
interface psf_cfg_if import psf_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);
endinterface

/* sv/prime_sieve_filter.sv */
// Top level of the prime sieve filter: trial division of each candidate by the stored primes.
// Depends on psf_pkg and the channel interfaces in psf_if.sv.
//
//  Channel   Dir  Payload                       Notes
//  i_cfg     in   limit[15:0]                   always ready, write only while idle
//  i_cand    in   candidate[15:0]               ready only in the idle state
//  o_prime   out  prime_value[15:0], status     registered, holds until taken
//
// A dropped candidate (below two or above the limit) is accepted in the idle state and gives no result.
// A kept candidate passes the fetch state, then for each stored prime a load state and one
// restoring remainder step per candidate bit, then the done state that posts the result.
// With an empty table a candidate goes straight to the done state; a divided one stops early.
// Reset clears the sequencer, the prime count and the output valid, and loads the limit with 280.
// A stalled output holds the sequencer in its final state until the result slot frees.
module prime_sieve_filter import psf_pkg::*; #(
    parameter int MAX_PRIMES = MAX_PRIMES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psf_cfg_if.sink       i_cfg,
    psf_cand_if.sink      i_cand,
    psf_prime_if.source   o_prime
);

    localparam int CW = $clog2(MAX_PRIMES + 1);
    localparam int AW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int BW = $clog2(VALUE_W);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_LOAD  = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [VALUE_W-1:0] r_limit, n_limit;
    logic [VALUE_W-1:0] r_cand, n_cand;
    logic [VALUE_W-1:0] r_shf, n_shf;
    logic [VALUE_W-1:0] r_div, n_div;
    logic [VALUE_W-1:0] r_rem, n_rem;
    logic [BW-1:0]      r_bit, n_bit;
    logic [CW-1:0]      r_addr, n_addr;
    logic [CW-1:0]      r_count, n_count;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_value, n_out_value;
    logic               r_out_status, n_out_status;

    logic [VALUE_W-1:0] r_mem [MAX_PRIMES];
    logic [VALUE_W-1:0] r_rd;
    logic               w_we;

    logic [VALUE_W:0]   w_trial;
    logic [VALUE_W:0]   w_diff;
    logic [VALUE_W-1:0] w_rem_next;
    logic               w_cand_acc;
    logic               w_in_range;
    logic               w_full;
    logic               w_slot_free;

    assign i_cfg.ready      = 1'b1;
    assign i_cand.ready     = (r_state == S_IDLE);
    assign o_prime.valid    = r_out_valid;
    assign o_prime.prime_value = r_out_value;
    assign o_prime.status   = r_out_status;

    assign w_cand_acc  = i_cand.valid && i_cand.ready;
    assign w_in_range  = (i_cand.candidate >= SMALLEST_PRIME) && (i_cand.candidate <= r_limit);
    assign w_full      = (r_count == CW'(MAX_PRIMES));
    assign w_slot_free = !r_out_valid || o_prime.ready;

    // Restoring remainder step: shift in the next candidate bit, subtract if it fits.
    assign w_trial    = {r_rem, r_shf[VALUE_W-1]};
    assign w_diff     = w_trial - {1'b0, r_div};
    assign w_rem_next = w_diff[VALUE_W] ? w_trial[VALUE_W-1:0] : w_diff[VALUE_W-1:0];

    // Table write when a new prime finds room.
    assign w_we = (r_state == S_DONE) && w_slot_free && !w_full;

    // Sequencer and datapath next state.
    always_comb begin
        n_state      = r_state;
        n_limit      = r_limit;
        n_cand       = r_cand;
        n_shf        = r_shf;
        n_div        = r_div;
        n_rem        = r_rem;
        n_bit        = r_bit;
        n_addr       = r_addr;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        if (i_cfg.valid) begin
            n_limit = i_cfg.limit;
        end
        if (r_out_valid && o_prime.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_cand_acc && w_in_range) begin
                    n_cand  = i_cand.candidate;
                    n_addr  = '0;
                    n_state = (r_count == '0) ? S_DONE : S_FETCH;
                end
            end
            S_FETCH: begin
                // Table read of the first prime is in flight.
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_div   = r_rd;
                n_rem   = '0;
                n_shf   = r_cand;
                n_bit   = BW'(VALUE_W - 1);
                n_addr  = r_addr + CW'(1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = w_rem_next;
                n_shf = r_shf << 1;
                n_bit = r_bit - BW'(1);
                if (r_bit == '0) begin
                    if (w_rem_next == '0) begin
                        n_state = S_IDLE;
                    end else if (r_addr == r_count) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_cand;
                    n_out_status = w_full ? ST_FULL : ST_STORED;
                    if (!w_full) begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= n_limit;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cand       <= n_cand;
        r_shf        <= n_shf;
        r_div        <= n_div;
        r_rem        <= n_rem;
        r_bit        <= n_bit;
        r_addr       <= n_addr;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // Prime table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[AW-1:0]] <= r_cand;
        end
        r_rd <= r_mem[r_addr[AW-1:0]];
    end

endmodule
